@@ rtl/core/ube_pkg.sv @@
// ----------------------------------------------------------------------------
// ube_pkg
// Shared types, widths, register codes and saturation helper for the
// Urey-Bradley term evaluator.
// ----------------------------------------------------------------------------
package ube_pkg;

   localparam int ATOM_INDEX_BITS = 20;
   localparam int COORD_W         = 32;
   localparam int LEN_W           = 31;
   localparam int RES_W           = 48;
   localparam int FRAC_BITS       = 16;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int SQ_W            = 2 * DIFF_W;
   localparam int ROOT_BITS       = DIFF_W;
   localparam int DT_W            = ROOT_BITS + 2;
   localparam int MUL_IN_W        = RES_W + 1;
   localparam int MAG_W           = RES_W;
   localparam int MUL_LAT         = 4;
   localparam int DIV_Q_BITS      = RES_W;
   localparam int DIV_LAT         = DIV_Q_BITS + 2;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [2:0] REG_UNIT_SCALE   = 3'd0;
   localparam logic [2:0] REG_CUBIC_COEF   = 3'd1;
   localparam logic [2:0] REG_QUARTIC_COEF = 3'd2;
   localparam logic [2:0] REG_ENERGY_EN    = 3'd3;
   localparam logic [2:0] REG_GRADIENT_EN  = 3'd4;
   localparam logic [2:0] REG_VIRIAL_EN    = 3'd5;

   localparam logic [31:0] UNIT_SCALE_RESET = 32'h0001_0000;

   typedef logic signed [RES_W-1:0]    res_type;
   typedef logic signed [MUL_IN_W-1:0] mul_in_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;

   localparam res_type RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
   localparam res_type RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

   typedef struct packed {
      logic [ATOM_INDEX_BITS-1:0] index_a;
      logic [ATOM_INDEX_BITS-1:0] index_c;
      logic signed [COORD_W-1:0]  pos_a_x;
      logic signed [COORD_W-1:0]  pos_a_y;
      logic signed [COORD_W-1:0]  pos_a_z;
      logic signed [COORD_W-1:0]  pos_c_x;
      logic signed [COORD_W-1:0]  pos_c_y;
      logic signed [COORD_W-1:0]  pos_c_z;
      logic [LEN_W-1:0]           ideal_length;
      logic [LEN_W-1:0]           force_const;
   } req_type;

   typedef struct packed {
      logic [ATOM_INDEX_BITS-1:0] out_index_a;
      logic [ATOM_INDEX_BITS-1:0] out_index_c;
      logic signed [RES_W-1:0]    energy;
      logic signed [RES_W-1:0]    grad_x;
      logic signed [RES_W-1:0]    grad_y;
      logic signed [RES_W-1:0]    grad_z;
      logic signed [RES_W-1:0]    vir_xx;
      logic signed [RES_W-1:0]    vir_yx;
      logic signed [RES_W-1:0]    vir_zx;
      logic signed [RES_W-1:0]    vir_yy;
      logic signed [RES_W-1:0]    vir_zy;
      logic signed [RES_W-1:0]    vir_zz;
   } rsp_type;

   // apply sign to a magnitude, clamping when it does not fit
   function automatic res_type sign_sat(input logic big, input logic neg,
                                        input logic [RES_W-2:0] m);
      res_type v;
      v = res_type'({1'b0, m});
      if (big) begin
         return neg ? RES_MIN : RES_MAX;
      end
      return neg ? -v : v;
   endfunction

endpackage

@@ rtl/core/ube_delay.sv @@
// ----------------------------------------------------------------------------
// ube_delay
// Fixed-length shift line that keeps operands aligned with the pipeline.
// ----------------------------------------------------------------------------
module ube_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] taps_ff [DEPTH];

   always_ff @(posedge clock) begin
      taps_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         taps_ff[i] <= taps_ff[i-1];
      end
   end

   assign dout = taps_ff[DEPTH-1];
endmodule

@@ rtl/core/ube_mulsh.sv @@
// ----------------------------------------------------------------------------
// ube_mulsh
// Four-stage signed multiply, rounded right shift (halves away from zero)
// and saturation to 48 bits.
// ----------------------------------------------------------------------------
module ube_mulsh #(
   parameter int SHIFT = 16
) (
   input  logic                clock,
   input  ube_pkg::mul_in_type a,
   input  ube_pkg::mul_in_type b,
   output ube_pkg::res_type    p
);
   import ube_pkg::*;

   localparam int HALF_W = MAG_W / 2;
   localparam int PP_W   = 2 * HALF_W;
   localparam int PROD_W = 2 * MAG_W;

   logic [MAG_W-1:0]  ma_in, mb_in;
   logic [MAG_W-1:0]  ma_ff, mb_ff;
   logic [2:0]        neg_ff;
   logic [PP_W-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] rnd, scaled;
   res_type           p_ff;

   always_comb begin
      ma_in  = MAG_W'(a[MUL_IN_W-1] ? -a : a);
      mb_in  = MAG_W'(b[MUL_IN_W-1] ? -b : b);
      rnd    = prod_ff + (PROD_W'(1) << (SHIFT - 1));
      scaled = rnd >> SHIFT;
   end

   always_ff @(posedge clock) begin
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      neg_ff[0] <= a[MUL_IN_W-1] ^ b[MUL_IN_W-1];
      // partial products
      ll_ff     <= ma_ff[HALF_W-1:0] * mb_ff[HALF_W-1:0];
      lh_ff     <= ma_ff[HALF_W-1:0] * mb_ff[MAG_W-1:HALF_W];
      hl_ff     <= ma_ff[MAG_W-1:HALF_W] * mb_ff[HALF_W-1:0];
      hh_ff     <= ma_ff[MAG_W-1:HALF_W] * mb_ff[MAG_W-1:HALF_W];
      neg_ff[1] <= neg_ff[0];
      prod_ff   <= (PROD_W'(hh_ff) << MAG_W)
                 + ((PROD_W'(lh_ff) + PROD_W'(hl_ff)) << HALF_W)
                 + PROD_W'(ll_ff);
      neg_ff[2] <= neg_ff[1];
      p_ff      <= sign_sat(|scaled[PROD_W-1:RES_W-1], neg_ff[2], scaled[RES_W-2:0]);
   end

   assign p = p_ff;
endmodule

@@ rtl/core/ube_sqrt.sv @@
// ----------------------------------------------------------------------------
// ube_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ube_sqrt (
   input  logic                          clock,
   input  logic [ube_pkg::SQ_W-1:0]      radicand,
   output logic [ube_pkg::ROOT_BITS-1:0] root
);
   import ube_pkg::*;

   localparam int RW = SQ_W + 1;

   logic [RW-1:0]        rem_ff  [ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
      localparam int B = ROOT_BITS - 1 - s;
      logic [RW-1:0]        rem_prev, trial, rem_in;
      logic [ROOT_BITS-1:0] root_prev, root_in;

      if (s == 0) begin : g_first
         assign rem_prev  = RW'(radicand);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      // (2*root + 2^b) * 2^b, the growth of root^2 when bit b is set
      assign trial = (RW'(root_prev) << (B + 1)) | (RW'(1) << (2 * B));

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_BITS'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[s] <= root_in;
      end

      if (s < ROOT_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in;
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];
endmodule

@@ rtl/core/ube_div.sv @@
// ----------------------------------------------------------------------------
// ube_div
// Pipelined rounded divide of (|deddt| << 16) by r, one quotient bit per
// stage, with sign, saturation and zero-divisor handling.
// ----------------------------------------------------------------------------
module ube_div (
   input  logic                          clock,
   input  ube_pkg::res_type              dividend,
   input  logic [ube_pkg::ROOT_BITS-1:0] divisor,
   output ube_pkg::res_type              quotient
);
   import ube_pkg::*;

   localparam int DIVD_W = MAG_W + FRAC_BITS;

   typedef struct packed {
      logic                  neg;
      logic                  zero;
      logic                  ovf;
      logic [ROOT_BITS-1:0]  dsr;
      logic [ROOT_BITS-1:0]  rem;
      logic [DIV_Q_BITS-1:0] lowq;
   } div_stage_type;

   logic [MAG_W-1:0]  mag;
   logic [DIVD_W-1:0] num;
   div_stage_type     st_ff [DIV_Q_BITS+1];
   res_type           q_ff;

   always_comb begin
      mag = MAG_W'(dividend[RES_W-1] ? -dividend : dividend);
      num = {mag, {FRAC_BITS{1'b0}}} + DIVD_W'(divisor >> 1);
   end

   always_ff @(posedge clock) begin
      st_ff[0].neg  <= dividend[RES_W-1];
      st_ff[0].zero <= (divisor == '0);
      // quotient of 2^48 or more saturates whatever the sign
      st_ff[0].ovf  <= ROOT_BITS'(num[DIVD_W-1:MAG_W]) >= divisor;
      st_ff[0].dsr  <= divisor;
      st_ff[0].rem  <= ROOT_BITS'(num[DIVD_W-1:MAG_W]);
      st_ff[0].lowq <= num[MAG_W-1:0];
   end

   for (genvar s = 1; s <= DIV_Q_BITS; s++) begin : g_stage
      logic [ROOT_BITS:0] shifted;
      logic               ge;

      assign shifted = {st_ff[s-1].rem, st_ff[s-1].lowq[DIV_Q_BITS-1]};
      assign ge      = shifted >= {1'b0, st_ff[s-1].dsr};

      always_ff @(posedge clock) begin
         st_ff[s].neg  <= st_ff[s-1].neg;
         st_ff[s].zero <= st_ff[s-1].zero;
         st_ff[s].ovf  <= st_ff[s-1].ovf;
         st_ff[s].dsr  <= st_ff[s-1].dsr;
         st_ff[s].rem  <= ROOT_BITS'(ge ? shifted - {1'b0, st_ff[s-1].dsr} : shifted);
         st_ff[s].lowq <= {st_ff[s-1].lowq[DIV_Q_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff[DIV_Q_BITS].zero) begin
         q_ff <= '0;
      end else begin
         q_ff <= sign_sat(st_ff[DIV_Q_BITS].ovf | st_ff[DIV_Q_BITS].lowq[DIV_Q_BITS-1],
                          st_ff[DIV_Q_BITS].neg, st_ff[DIV_Q_BITS].lowq[DIV_Q_BITS-2:0]);
      end
   end

   assign quotient = q_ff;
endmodule

@@ rtl/core/urey_bradley_term_eval_unit.sv @@
// Throughput: one term per cycle; busy never rises and results cannot be held off.
// The 33-stage square root and the 50-stage divider set most of the latency.
// Reset (synchronous) clears the valid pipeline and restores register defaults;
// terms in flight at reset are dropped.
// ----------------------------------------------------------------------------
// urey_bradley_term_eval_unit
// Pipelined Urey-Bradley 1-3 term: distance, anharmonic energy, gradient and
// virial in Q32.16 with APB-style control registers.
// ----------------------------------------------------------------------------
module urey_bradley_term_eval_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  ube_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output ube_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ube_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ube_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ube_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import ube_pkg::*;

   localparam int ST_D    = 1;
   localparam int ST_ROOT = ST_D + 2 + ROOT_BITS;
   localparam int ST_DT   = ST_ROOT + 1;
   localparam int ST_L1   = ST_DT + MUL_LAT;
   localparam int ST_L2   = ST_L1 + MUL_LAT;
   localparam int ST_FG   = ST_L2 + 1;
   localparam int ST_L3   = ST_FG + MUL_LAT;
   localparam int ST_DE   = ST_L3 + DIV_LAT;
   localparam int ST_GRAD = ST_DE + MUL_LAT;
   localparam int ST_VIR  = ST_GRAD + MUL_LAT;
   localparam int ST_OUT  = ST_VIR + 1;
   localparam int SUM_W   = RES_W + 2;
   localparam int ONE_Q16 = 65536;

   function automatic res_type sat_sum(input logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(RES_MAX)) begin
         return RES_MAX;
      end
      if (v < SUM_W'(RES_MIN)) begin
         return RES_MIN;
      end
      return res_type'(v);
   endfunction

   logic        accept, csr_wr;
   logic [2:0]  csr_idx;
   logic [31:0] unit_scale_ff, cubic_ff, quartic_ff;
   logic        energy_en_ff, grad_en_ff, vir_en_ff;
   logic [ST_OUT:0] valid_ff;

   req_type              in_ff;
   diff_type             d_ff [3];
   logic [DIFF_W-1:0]    dmag [3];
   logic [SQ_W-1:0]      sq_ff [3];
   logic [SQ_W-1:0]      sum_ff;
   logic [ROOT_BITS-1:0] root, root_l3;
   logic [LEN_W-1:0]     ideal_d, force_d;
   logic signed [DT_W-1:0] dt_ff, dt_l1;
   res_type dt2, kq, c1, q1, e1, c2, q2, g1;
   res_type f_ff, g_ff, e1_ff, g1_ff, energy_raw, deddt, de, energy_d;
   logic signed [SUM_W-1:0] f_sum, g_sum;
   logic signed [33:0]      cub3;
   logic [3*DIFF_W-1:0]     d_pack, d_de_pack, d_gr_pack;
   diff_type d_de [3];
   diff_type d_gr [3];
   res_type  grad [3];
   res_type  grad_d [3];
   res_type  vir [6];
   logic [3*RES_W-1:0] grad_pack, grad_d_pack;
   logic [2*ATOM_INDEX_BITS-1:0] idx_d;
   rsp_type  rsp_ff;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_scale_ff <= UNIT_SCALE_RESET;
         cubic_ff      <= '0;
         quartic_ff    <= '0;
         energy_en_ff  <= 1'b1;
         grad_en_ff    <= 1'b1;
         vir_en_ff     <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_UNIT_SCALE:   unit_scale_ff <= pwdata;
            REG_CUBIC_COEF:   cubic_ff      <= pwdata;
            REG_QUARTIC_COEF: quartic_ff    <= pwdata;
            REG_ENERGY_EN:    energy_en_ff  <= pwdata[0];
            REG_GRADIENT_EN:  grad_en_ff    <= pwdata[0];
            REG_VIRIAL_EN:    vir_en_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_UNIT_SCALE:   prdata = unit_scale_ff;
         REG_CUBIC_COEF:   prdata = cubic_ff;
         REG_QUARTIC_COEF: prdata = quartic_ff;
         REG_ENERGY_EN:    prdata = {31'b0, energy_en_ff};
         REG_GRADIENT_EN:  prdata = {31'b0, grad_en_ff};
         REG_VIRIAL_EN:    prdata = {31'b0, vir_en_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ST_OUT-1:0], accept};
      end
   end

   // separation, squares and their sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dmag[i] = DIFF_W'(d_ff[i][DIFF_W-1] ? -d_ff[i] : d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= req_data;
      d_ff[0] <= diff_type'(in_ff.pos_a_x) - diff_type'(in_ff.pos_c_x);
      d_ff[1] <= diff_type'(in_ff.pos_a_y) - diff_type'(in_ff.pos_c_y);
      d_ff[2] <= diff_type'(in_ff.pos_a_z) - diff_type'(in_ff.pos_c_z);
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= dmag[i] * dmag[i];
      end
      sum_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   ube_sqrt u_sqrt (.clock(clock), .radicand(sum_ff), .root(root));

   ube_delay #(.WIDTH(LEN_W), .DEPTH(ST_ROOT)) u_dly_ideal (
      .clock(clock), .din(in_ff.ideal_length), .dout(ideal_d));
   ube_delay #(.WIDTH(LEN_W), .DEPTH(ST_DT)) u_dly_force (
      .clock(clock), .din(in_ff.force_const), .dout(force_d));

   always_ff @(posedge clock) begin
      dt_ff <= $signed({2'b0, root}) - $signed({4'b0, ideal_d});
   end

   ube_mulsh #(.SHIFT(16)) u_dt2 (.clock(clock), .a(mul_in_type'(dt_ff)),
      .b(mul_in_type'(dt_ff)), .p(dt2));
   ube_mulsh #(.SHIFT(16)) u_k (.clock(clock),
      .a(mul_in_type'($signed({1'b0, unit_scale_ff}))),
      .b(mul_in_type'($signed({1'b0, force_d}))), .p(kq));

   ube_delay #(.WIDTH(DT_W), .DEPTH(ST_L1 - ST_DT)) u_dly_dt (
      .clock(clock), .din(dt_ff), .dout(dt_l1));

   assign cub3 = $signed({cubic_ff[31], cubic_ff, 1'b0})
               + $signed({{2{cubic_ff[31]}}, cubic_ff});

   ube_mulsh #(.SHIFT(16)) u_c1 (.clock(clock), .a(mul_in_type'($signed(cubic_ff))),
      .b(mul_in_type'($signed(dt_l1))), .p(c1));
   ube_mulsh #(.SHIFT(16)) u_q1 (.clock(clock), .a(mul_in_type'($signed(quartic_ff))),
      .b(mul_in_type'(dt2)), .p(q1));
   ube_mulsh #(.SHIFT(16)) u_e1 (.clock(clock), .a(mul_in_type'(kq)),
      .b(mul_in_type'(dt2)), .p(e1));
   // 1.5 * cubic folded into 3 * cubic with one more bit of shift
   ube_mulsh #(.SHIFT(17)) u_c2 (.clock(clock), .a(mul_in_type'(cub3)),
      .b(mul_in_type'($signed(dt_l1))), .p(c2));
   ube_mulsh #(.SHIFT(15)) u_q2 (.clock(clock), .a(mul_in_type'($signed(quartic_ff))),
      .b(mul_in_type'(dt2)), .p(q2));
   ube_mulsh #(.SHIFT(15)) u_g1 (.clock(clock), .a(mul_in_type'(kq)),
      .b(mul_in_type'($signed(dt_l1))), .p(g1));

   always_comb begin
      f_sum = SUM_W'(ONE_Q16) + SUM_W'(c1) + SUM_W'(q1);
      g_sum = SUM_W'(ONE_Q16) + SUM_W'(c2) + SUM_W'(q2);
   end

   always_ff @(posedge clock) begin
      f_ff  <= sat_sum(f_sum);
      g_ff  <= sat_sum(g_sum);
      e1_ff <= e1;
      g1_ff <= g1;
   end

   ube_mulsh #(.SHIFT(16)) u_energy (.clock(clock), .a(mul_in_type'(e1_ff)),
      .b(mul_in_type'(f_ff)), .p(energy_raw));
   ube_mulsh #(.SHIFT(16)) u_deddt (.clock(clock), .a(mul_in_type'(g1_ff)),
      .b(mul_in_type'(g_ff)), .p(deddt));

   ube_delay #(.WIDTH(ROOT_BITS), .DEPTH(ST_L3 - ST_ROOT)) u_dly_root (
      .clock(clock), .din(root), .dout(root_l3));

   ube_div u_div (.clock(clock), .dividend(deddt), .divisor(root_l3), .quotient(de));

   assign d_pack = {d_ff[2], d_ff[1], d_ff[0]};

   ube_delay #(.WIDTH(3*DIFF_W), .DEPTH(ST_DE - ST_D)) u_dly_d_de (
      .clock(clock), .din(d_pack), .dout(d_de_pack));
   ube_delay #(.WIDTH(3*DIFF_W), .DEPTH(MUL_LAT)) u_dly_d_gr (
      .clock(clock), .din(d_de_pack), .dout(d_gr_pack));

   for (genvar i = 0; i < 3; i++) begin : g_grad
      assign d_de[i] = diff_type'(d_de_pack[i*DIFF_W +: DIFF_W]);
      assign d_gr[i] = diff_type'(d_gr_pack[i*DIFF_W +: DIFF_W]);
      assign grad_pack[i*RES_W +: RES_W] = grad[i];
      assign grad_d[i] = res_type'(grad_d_pack[i*RES_W +: RES_W]);
      ube_mulsh #(.SHIFT(16)) u_grad (.clock(clock), .a(mul_in_type'(de)),
         .b(mul_in_type'(d_de[i])), .p(grad[i]));
   end

   ube_mulsh #(.SHIFT(16)) u_vxx (.clock(clock), .a(mul_in_type'(d_gr[0])),
      .b(mul_in_type'(grad[0])), .p(vir[0]));
   ube_mulsh #(.SHIFT(16)) u_vyx (.clock(clock), .a(mul_in_type'(d_gr[1])),
      .b(mul_in_type'(grad[0])), .p(vir[1]));
   ube_mulsh #(.SHIFT(16)) u_vzx (.clock(clock), .a(mul_in_type'(d_gr[2])),
      .b(mul_in_type'(grad[0])), .p(vir[2]));
   ube_mulsh #(.SHIFT(16)) u_vyy (.clock(clock), .a(mul_in_type'(d_gr[1])),
      .b(mul_in_type'(grad[1])), .p(vir[3]));
   ube_mulsh #(.SHIFT(16)) u_vzy (.clock(clock), .a(mul_in_type'(d_gr[2])),
      .b(mul_in_type'(grad[1])), .p(vir[4]));
   ube_mulsh #(.SHIFT(16)) u_vzz (.clock(clock), .a(mul_in_type'(d_gr[2])),
      .b(mul_in_type'(grad[2])), .p(vir[5]));

   ube_delay #(.WIDTH(RES_W), .DEPTH(ST_VIR - ST_L3)) u_dly_energy (
      .clock(clock), .din(energy_raw), .dout(energy_d));
   ube_delay #(.WIDTH(3*RES_W), .DEPTH(ST_VIR - ST_GRAD)) u_dly_grad (
      .clock(clock), .din(grad_pack), .dout(grad_d_pack));
   ube_delay #(.WIDTH(2*ATOM_INDEX_BITS), .DEPTH(ST_VIR)) u_dly_idx (
      .clock(clock), .din({in_ff.index_a, in_ff.index_c}), .dout(idx_d));

   // output beat, disabled groups forced to zero
   always_ff @(posedge clock) begin
      rsp_ff.out_index_a <= idx_d[2*ATOM_INDEX_BITS-1:ATOM_INDEX_BITS];
      rsp_ff.out_index_c <= idx_d[ATOM_INDEX_BITS-1:0];
      rsp_ff.energy      <= energy_en_ff ? energy_d : '0;
      rsp_ff.grad_x      <= grad_en_ff ? grad_d[0] : '0;
      rsp_ff.grad_y      <= grad_en_ff ? grad_d[1] : '0;
      rsp_ff.grad_z      <= grad_en_ff ? grad_d[2] : '0;
      rsp_ff.vir_xx      <= (grad_en_ff && vir_en_ff) ? vir[0] : '0;
      rsp_ff.vir_yx      <= (grad_en_ff && vir_en_ff) ? vir[1] : '0;
      rsp_ff.vir_zx      <= (grad_en_ff && vir_en_ff) ? vir[2] : '0;
      rsp_ff.vir_yy      <= (grad_en_ff && vir_en_ff) ? vir[3] : '0;
      rsp_ff.vir_zy      <= (grad_en_ff && vir_en_ff) ? vir[4] : '0;
      rsp_ff.vir_zz      <= (grad_en_ff && vir_en_ff) ? vir[5] : '0;
   end

   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, ST_OUT + 1))
      else $error("result beat without a matching accepted term");

   a_energy_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !energy_en_ff |-> rsp_data.energy == '0)
      else $error("energy nonzero while disabled");

   a_virial_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!grad_en_ff || !vir_en_ff) |->
         rsp_data.vir_xx == '0 && rsp_data.vir_yy == '0 && rsp_data.vir_zz == '0 &&
         rsp_data.vir_yx == '0 && rsp_data.vir_zx == '0 && rsp_data.vir_zy == '0)
      else $error("virial nonzero while disabled");
`endif
endmodule
